FILE: hdl/fsrd_pkg.sv
// ----------------------------------------------------------------------------
// fsrd_pkg: shared definitions for the sparse radix digit converter
// Register indexes, field widths, reset values and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package fsrd_pkg;

  // field widths
  localparam int BASE_W    = 7;
  localparam int PLACES_W  = 6;
  localparam int DIGIT_W   = 6;
  localparam int EXP_W     = 6;
  localparam int IN_W      = 32;
  localparam int CFG_IDX_W = 1;

  // bits needed to index one bit of the base
  localparam int BASE_IDX_W = 3;

  // register reset values and legal ranges
  localparam logic [BASE_W-1:0]   BASE_RESET   = 7'd60;
  localparam logic [PLACES_W-1:0] PLACES_RESET = 6'd4;
  localparam logic [BASE_W-1:0]   BASE_MIN     = 7'd2;
  localparam logic [BASE_W-1:0]   BASE_MAX     = 7'd64;
  localparam logic [PLACES_W-1:0] PLACES_MAX   = 6'd32;

  // parameter defaults
  localparam int MAX_DIGITS_DEF = 20;
  localparam int WHOLE_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIGIT_BASE      = 1'b0,
    REG_FRACTION_PLACES = 1'b1
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_IDIG,
    S_FCHK,
    S_MUL,
    S_FDIG,
    S_FIN
  } seq_state_t;

endpackage

`default_nettype wire

FILE: hdl/fixed_to_sparse_radix_digits.sv
// ----------------------------------------------------------------------------
// fixed_to_sparse_radix_digits: sparse radix digit expansion
// Splits an unsigned whole.fraction magnitude into nonzero digits of a
// configurable base, each tagged with its exponent, using one shared
// add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------
//  input    | in_whole_part, in_frac_part             | start & !busy
//  result   | out_digit_value, out_digit_exponent,    | out_strobe, 1 cycle
//           | out_is_empty, out_is_last               |
//  config   | cfg_index, cfg_data                     | cfg_we
//
// Each integer digit takes a restoring division through the shared unit, one
// restoring division bit per cycle, then a digit state; each fraction place
// takes a check state, seven shift-add steps over the base bits and a digit
// state. A request visits the integer places, then the fraction places, and
// stops once MAX_DIGITS are kept. busy is high from the cycle after acceptance
// until the final result has been registered. Results are held back one
// digit so that is_last is known; the receiver cannot stall. Reset is
// synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_to_sparse_radix_digits #(
  parameter int MAX_DIGITS = fsrd_pkg::MAX_DIGITS_DEF,
  parameter int WHOLE_BITS = fsrd_pkg::WHOLE_BITS_DEF,
  parameter int FRAC_BITS  = fsrd_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [fsrd_pkg::IN_W-1:0]          in_whole_part,
  input  wire logic [fsrd_pkg::IN_W-1:0]          in_frac_part,
  // results
  output logic                                    out_strobe,
  output logic [fsrd_pkg::DIGIT_W-1:0]            out_digit_value,
  output logic signed [fsrd_pkg::EXP_W-1:0]       out_digit_exponent,
  output logic                                    out_is_empty,
  output logic                                    out_is_last,
  // configuration
  input  wire logic                               cfg_we,
  input  wire logic [fsrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fsrd_pkg::BASE_W-1:0]        cfg_data
);

  localparam int AW   = FRAC_BITS + 6;            // product of fraction and base
  localparam int CW   = $clog2(MAX_DIGITS + 1);   // kept digit count
  localparam int CNTW = $clog2(WHOLE_BITS);       // step counter
  localparam int RW   = fsrd_pkg::BASE_W;         // division remainder

  // configuration registers
  logic [fsrd_pkg::BASE_W-1:0]   cfg_base_r;
  logic [fsrd_pkg::PLACES_W-1:0] cfg_places_r;

  // sequencer and datapath registers
  fsrd_pkg::seq_state_t state_r, state_nxt;
  logic [WHOLE_BITS-1:0]            whole_r, whole_nxt;
  logic [RW-1:0]                    rem_r, rem_nxt;
  logic [FRAC_BITS-1:0]             frac_r, frac_nxt;
  logic [AW-1:0]                    acc_r, acc_nxt;
  logic [CNTW-1:0]                  cnt_r, cnt_nxt;
  logic [fsrd_pkg::BASE_W-1:0]      base_r, base_nxt;
  logic [fsrd_pkg::PLACES_W-1:0]    places_r, places_nxt;
  logic [fsrd_pkg::PLACES_W-1:0]    fidx_r, fidx_nxt;
  logic signed [fsrd_pkg::EXP_W-1:0] expo_r, expo_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic                             pend_r, pend_nxt;
  logic [fsrd_pkg::DIGIT_W-1:0]     pend_digit_r, pend_digit_nxt;
  logic signed [fsrd_pkg::EXP_W-1:0] pend_exp_r, pend_exp_nxt;

  // output registers
  logic                              emit;
  logic [fsrd_pkg::DIGIT_W-1:0]      emit_digit;
  logic signed [fsrd_pkg::EXP_W-1:0] emit_exp;
  logic                              emit_empty;
  logic                              emit_last;

  // input fields cut or extended to the working widths
  logic [63:0] whole_ext;
  logic [63:0] frac_ext;
  assign whole_ext = {32'd0, in_whole_part};
  assign frac_ext  = {32'd0, in_frac_part};

  // clamped configuration taken at acceptance
  logic [fsrd_pkg::BASE_W-1:0]   base_clamped;
  logic [fsrd_pkg::PLACES_W-1:0] places_clamped;
  always_comb begin
    if (cfg_base_r < fsrd_pkg::BASE_MIN) begin
      base_clamped = fsrd_pkg::BASE_MIN;
    end else if (cfg_base_r > fsrd_pkg::BASE_MAX) begin
      base_clamped = fsrd_pkg::BASE_MAX;
    end else begin
      base_clamped = cfg_base_r;
    end
    if (cfg_places_r > fsrd_pkg::PLACES_MAX) begin
      places_clamped = fsrd_pkg::PLACES_MAX;
    end else begin
      places_clamped = cfg_places_r;
    end
  end

  // shared add/subtract unit
  logic [AW-1:0] alu_a, alu_b;
  logic          alu_sub;
  logic [AW:0]   alu_res;
  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + {{AW{1'b0}}, alu_sub};

  logic [RW-1:0] rem_try;
  assign rem_try = {rem_r[RW-2:0], whole_r[WHOLE_BITS-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      fsrd_pkg::S_DIV: begin
        alu_a   = AW'(rem_try);
        alu_b   = AW'(base_r);
        alu_sub = 1'b1;
      end
      fsrd_pkg::S_MUL: begin
        alu_a = {acc_r[AW-2:0], 1'b0};
        alu_b = base_r[cnt_r[fsrd_pkg::BASE_IDX_W-1:0]] ? AW'(frac_r) : '0;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // digit found in this cycle, if any
  logic                         dig_valid;
  logic [fsrd_pkg::DIGIT_W-1:0] dig_value;
  logic                         count_full;
  always_comb begin
    dig_valid = 1'b0;
    dig_value = '0;
    case (state_r)
      fsrd_pkg::S_IDIG: begin
        dig_value = rem_r[fsrd_pkg::DIGIT_W-1:0];
        dig_valid = (dig_value != '0);
      end
      fsrd_pkg::S_FDIG: begin
        dig_value = acc_r[FRAC_BITS +: fsrd_pkg::DIGIT_W];
        dig_valid = (dig_value != '0);
      end
      default: begin
        dig_valid = 1'b0;
      end
    endcase
  end
  assign count_full = dig_valid && ((count_r + CW'(1)) == CW'(MAX_DIGITS));

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    whole_nxt      = whole_r;
    rem_nxt        = rem_r;
    frac_nxt       = frac_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    base_nxt       = base_r;
    places_nxt     = places_r;
    fidx_nxt       = fidx_r;
    expo_nxt       = expo_r;
    count_nxt      = count_r;
    pend_nxt       = pend_r;
    pend_digit_nxt = pend_digit_r;
    pend_exp_nxt   = pend_exp_r;
    emit           = 1'b0;
    emit_digit     = pend_digit_r;
    emit_exp       = pend_exp_r;
    emit_empty     = 1'b0;
    emit_last      = 1'b0;

    // a new digit pushes out the one held back
    if (dig_valid) begin
      emit           = pend_r;
      pend_nxt       = 1'b1;
      pend_digit_nxt = dig_value;
      pend_exp_nxt   = expo_r;
      count_nxt      = count_r + CW'(1);
    end

    case (state_r)
      fsrd_pkg::S_IDLE: begin
        if (start) begin
          whole_nxt  = whole_ext[WHOLE_BITS-1:0];
          frac_nxt   = frac_ext[FRAC_BITS-1:0];
          base_nxt   = base_clamped;
          places_nxt = places_clamped;
          expo_nxt   = '0;
          count_nxt  = '0;
          pend_nxt   = 1'b0;
          fidx_nxt   = '0;
          rem_nxt    = '0;
          cnt_nxt    = CNTW'(WHOLE_BITS - 1);
          if (whole_ext[WHOLE_BITS-1:0] != '0) begin
            state_nxt = fsrd_pkg::S_DIV;
          end else begin
            expo_nxt  = -fsrd_pkg::EXP_W'(1);
            state_nxt = fsrd_pkg::S_FCHK;
          end
        end
      end
      // one restoring division bit per cycle
      fsrd_pkg::S_DIV: begin
        if (alu_res[AW]) begin
          rem_nxt   = alu_res[RW-1:0];
          whole_nxt = {whole_r[WHOLE_BITS-2:0], 1'b1};
        end else begin
          rem_nxt   = rem_try;
          whole_nxt = {whole_r[WHOLE_BITS-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = fsrd_pkg::S_IDIG;
        end else begin
          cnt_nxt = cnt_r - CNTW'(1);
        end
      end
      // integer digit in the remainder, quotient in whole_r
      fsrd_pkg::S_IDIG: begin
        rem_nxt = '0;
        cnt_nxt = CNTW'(WHOLE_BITS - 1);
        if (count_full) begin
          state_nxt = fsrd_pkg::S_FIN;
        end else if (whole_r != '0) begin
          expo_nxt  = expo_r + fsrd_pkg::EXP_W'(1);
          state_nxt = fsrd_pkg::S_DIV;
        end else begin
          expo_nxt  = -fsrd_pkg::EXP_W'(1);
          state_nxt = fsrd_pkg::S_FCHK;
        end
      end
      // next fraction place, or done
      fsrd_pkg::S_FCHK: begin
        if ((fidx_r == places_r) || (frac_r == '0)) begin
          state_nxt = fsrd_pkg::S_FIN;
        end else begin
          acc_nxt   = '0;
          cnt_nxt   = CNTW'(fsrd_pkg::BASE_W - 1);
          state_nxt = fsrd_pkg::S_MUL;
        end
      end
      // shift-add over the base bits, top bit first
      fsrd_pkg::S_MUL: begin
        acc_nxt = alu_res[AW-1:0];
        if (cnt_r == '0) begin
          state_nxt = fsrd_pkg::S_FDIG;
        end else begin
          cnt_nxt = cnt_r - CNTW'(1);
        end
      end
      // fraction digit above the binary point of the product
      fsrd_pkg::S_FDIG: begin
        frac_nxt = acc_r[FRAC_BITS-1:0];
        expo_nxt = expo_r - fsrd_pkg::EXP_W'(1);
        fidx_nxt = fidx_r + fsrd_pkg::PLACES_W'(1);
        if (count_full) begin
          state_nxt = fsrd_pkg::S_FIN;
        end else begin
          state_nxt = fsrd_pkg::S_FCHK;
        end
      end
      // flush the held digit as the last one, or report empty
      fsrd_pkg::S_FIN: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        if (!pend_r) begin
          emit_digit = '0;
          emit_exp   = '0;
          emit_empty = 1'b1;
        end
        pend_nxt  = 1'b0;
        state_nxt = fsrd_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fsrd_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fsrd_pkg::S_IDLE;
      cfg_base_r   <= fsrd_pkg::BASE_RESET;
      cfg_places_r <= fsrd_pkg::PLACES_RESET;
      pend_r       <= 1'b0;
      count_r      <= '0;
      out_strobe   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_r     <= pend_nxt;
      count_r    <= count_nxt;
      out_strobe <= emit;
      if (cfg_we) begin
        case (fsrd_pkg::cfg_reg_t'(cfg_index))
          fsrd_pkg::REG_DIGIT_BASE:      cfg_base_r   <= cfg_data;
          fsrd_pkg::REG_FRACTION_PLACES: cfg_places_r <= cfg_data[fsrd_pkg::PLACES_W-1:0];
          default: begin
            cfg_base_r <= cfg_base_r;
          end
        endcase
      end
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    whole_r      <= whole_nxt;
    rem_r        <= rem_nxt;
    frac_r       <= frac_nxt;
    acc_r        <= acc_nxt;
    cnt_r        <= cnt_nxt;
    base_r       <= base_nxt;
    places_r     <= places_nxt;
    fidx_r       <= fidx_nxt;
    expo_r       <= expo_nxt;
    pend_digit_r <= pend_digit_nxt;
    pend_exp_r   <= pend_exp_nxt;
    if (emit) begin
      out_digit_value    <= emit_digit;
      out_digit_exponent <= emit_exp;
      out_is_empty       <= emit_empty;
      out_is_last        <= emit_last;
    end
  end

  assign busy = (state_r != fsrd_pkg::S_IDLE);

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but sequencer stayed idle");

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_is_empty |-> (out_digit_value == '0) && out_is_last)
    else $error("empty result without zero digit or last mark");

  a_digit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_is_empty |-> out_digit_value != '0)
    else $error("zero digit emitted");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_DIGITS))
    else $error("kept digit count beyond limit");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_is_last |-> !busy || $past(state_r) == fsrd_pkg::S_FIN)
    else $error("last result while still converting");

endmodule

`default_nettype wire

FILE: tb/fixed_to_sparse_radix_digits_tb.sv
// ----------------------------------------------------------------------------
// fixed_to_sparse_radix_digits_tb: self-checking bench for the digit converter
// Drives whole.fraction requests under several base and place settings,
// predicts the sparse digit list of every accepted request and checks each
// result strobe against it in order, with random gaps between requests.
// ----------------------------------------------------------------------------
module fixed_to_sparse_radix_digits_tb;

  localparam int KEEP_DIGITS = fsrd_pkg::MAX_DIGITS_DEF;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE      = 10;

  typedef struct packed {
    logic [fsrd_pkg::IN_W-1:0] whole;
    logic [fsrd_pkg::IN_W-1:0] frac;
  } conv_req_t;

  typedef struct packed {
    logic [fsrd_pkg::DIGIT_W-1:0]      value;
    logic signed [fsrd_pkg::EXP_W-1:0] expo;
    logic                              empty;
    logic                              last;
  } digit_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [fsrd_pkg::IN_W-1:0] in_whole_part = '0;
  logic [fsrd_pkg::IN_W-1:0] in_frac_part = '0;
  logic cfg_we = 1'b0;
  logic [fsrd_pkg::CFG_IDX_W-1:0] cfg_index = fsrd_pkg::REG_DIGIT_BASE;
  logic [fsrd_pkg::BASE_W-1:0] cfg_data = '0;

  logic busy;
  logic out_strobe;
  logic [fsrd_pkg::DIGIT_W-1:0] out_digit_value;
  logic signed [fsrd_pkg::EXP_W-1:0] out_digit_exponent;
  logic out_is_empty;
  logic out_is_last;

  // queued requests, expected digits, mirrored registers
  conv_req_t conv_requests[$];
  digit_t    expected_digits[$];
  logic [fsrd_pkg::BASE_W-1:0]   base_mirror = fsrd_pkg::BASE_RESET;
  logic [fsrd_pkg::PLACES_W-1:0] places_mirror = fsrd_pkg::PLACES_RESET;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int gap_left = 0;
  bit no_gaps = 1'b0;

  fixed_to_sparse_radix_digits u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_whole_part      (in_whole_part),
    .in_frac_part       (in_frac_part),
    .out_strobe         (out_strobe),
    .out_digit_value    (out_digit_value),
    .out_digit_exponent (out_digit_exponent),
    .out_is_empty       (out_is_empty),
    .out_is_last        (out_is_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // expand one request into its nonzero digits under the mirrored registers
  function automatic void expand_digits(input logic [fsrd_pkg::IN_W-1:0] whole_in,
                                        input logic [fsrd_pkg::IN_W-1:0] frac_in);
    logic [fsrd_pkg::IN_W-1:0] whole;
    logic [fsrd_pkg::IN_W-1:0] frac;
    logic [63:0] prod;
    logic [fsrd_pkg::IN_W-1:0] d;
    logic [fsrd_pkg::BASE_W-1:0] radix;
    int places;
    int expo;
    digit_t r;
    digit_t found[$];
    whole = whole_in;
    frac = frac_in;
    radix = base_mirror;
    if (radix < fsrd_pkg::BASE_MIN) radix = fsrd_pkg::BASE_MIN;
    if (radix > fsrd_pkg::BASE_MAX) radix = fsrd_pkg::BASE_MAX;
    places = (places_mirror > fsrd_pkg::PLACES_MAX) ? int'(fsrd_pkg::PLACES_MAX)
                                                     : int'(places_mirror);
    // integer digits by repeated division, exponent 0 upward
    expo = 0;
    while (whole != 0) begin
      d = whole % {{(fsrd_pkg::IN_W-fsrd_pkg::BASE_W){1'b0}}, radix};
      if (d != 0 && found.size() < KEEP_DIGITS) begin
        r = '{value: d[fsrd_pkg::DIGIT_W-1:0], expo: expo[fsrd_pkg::EXP_W-1:0],
              empty: 1'b0, last: 1'b0};
        found.push_back(r);
      end
      whole = whole / {{(fsrd_pkg::IN_W-fsrd_pkg::BASE_W){1'b0}}, radix};
      expo++;
    end
    // fraction digits by repeated multiplication, stop once nothing is left
    expo = -1;
    for (int i = 0; i < places && frac != 0; i++) begin
      prod = {32'd0, frac} * {57'd0, radix};
      d = prod[63:32];
      frac = prod[31:0];
      if (d != 0 && found.size() < KEEP_DIGITS) begin
        r = '{value: d[fsrd_pkg::DIGIT_W-1:0], expo: expo[fsrd_pkg::EXP_W-1:0],
              empty: 1'b0, last: 1'b0};
        found.push_back(r);
      end
      expo--;
    end
    // empty expansion gives a single marker result
    if (found.size() == 0) begin
      r = '{value: '0, expo: '0, empty: 1'b1, last: 1'b1};
      found.push_back(r);
    end
    found[found.size()-1].last = 1'b1;
    foreach (found[k]) expected_digits.push_back(found[k]);
  endfunction

  // random request with a spread of magnitudes and terminating fractions
  function automatic conv_req_t random_request();
    conv_req_t q;
    case ($urandom_range(0, 7))
      0: q = '{whole: $urandom, frac: $urandom};
      1: q = '{whole: $urandom, frac: '0};
      2: q = '{whole: '0, frac: $urandom};
      3: q = '{whole: $urandom_range(0, 4095), frac: $urandom << $urandom_range(0, 31)};
      4: q = '{whole: $urandom >> $urandom_range(0, 31), frac: $urandom << $urandom_range(0, 31)};
      5: q = '{whole: $urandom >> $urandom_range(0, 31), frac: $urandom >> $urandom_range(0, 31)};
      6: q = '{whole: $urandom_range(0, 255), frac: $urandom_range(0, 255)};
      default: begin
        if ($urandom_range(0, 1) == 0) q = '{whole: '0, frac: '0};
        else q = '{whole: $urandom, frac: $urandom};
      end
    endcase
    return q;
  endfunction

  // request driver with per-request gaps and gap-free stretches
  always @(posedge clk) begin : drive_requests
    conv_req_t req;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
        gap_left = no_gaps ? 0 : $urandom_range(0, 18);
      end
      // hold a request until it is taken
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (conv_requests.size() > 0) begin
          req = conv_requests.pop_front();
          in_whole_part <= req.whole;
          in_frac_part <= req.frac;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // predict on acceptance, check every result strobe, watchdog
  always @(posedge clk) begin : check_results
    digit_t got;
    digit_t want;
    if (rst_n) begin
      if (start && !busy) begin
        expand_digits(in_whole_part, in_frac_part);
        quiet_cycles = 0;
      end
      if (out_strobe) begin
        quiet_cycles = 0;
        got = '{value: out_digit_value, expo: out_digit_exponent,
                empty: out_is_empty, last: out_is_last};
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d exp=%0d empty=%b last=%b",
                                    got.value, got.expo, got.empty, got.last));
        end else begin
          want = expected_digits.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "value %0d/%0d exp %0d/%0d empty %b/%b last %b/%b (got/want)",
              got.value, want.value, got.expo, want.expo,
              got.empty, want.empty, got.last, want.last));
        end
      end
      if (!(start && !busy) && !out_strobe) quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: %0d results still outstanding", expected_digits.size());
        $display("** fixed_to_sparse_radix_digits: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(input fsrd_pkg::cfg_reg_t idx,
                           input logic [fsrd_pkg::BASE_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fsrd_pkg::REG_DIGIT_BASE) base_mirror = value;
    else places_mirror = value[fsrd_pkg::PLACES_W-1:0];
  endtask

  // wait until every request is taken and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (conv_requests.size() != 0 || start || expected_digits.size() != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  // stimulus: reset-value requests, then phases of register settings
  initial begin : stimulus
    logic [fsrd_pkg::BASE_W-1:0] bases[12];
    logic [fsrd_pkg::BASE_W-1:0] places[12];
    bases  = '{7'd2,  7'd64, 7'd10, 7'd0,  7'd127, 7'd3,
               7'd16, 7'd7,  7'd1,  7'd60, 7'd36,  7'd2};
    places = '{7'd32, 7'd0,  7'd5,  7'd63, 7'd33,  7'd32,
               7'd8,  7'd31, 7'd1,  7'd4,  7'd20,  7'd12};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed requests under the reset base and places
    conv_requests.push_back('{whole: 32'h0,        frac: 32'h0});
    conv_requests.push_back('{whole: 32'hFFFFFFFF, frac: 32'h0});
    conv_requests.push_back('{whole: 32'h0,        frac: 32'hFFFFFFFF});
    conv_requests.push_back('{whole: 32'hFFFFFFFF, frac: 32'hFFFFFFFF});
    conv_requests.push_back('{whole: 32'd1,        frac: 32'h0});
    conv_requests.push_back('{whole: 32'd60,       frac: 32'h0});
    conv_requests.push_back('{whole: 32'd59,       frac: 32'h0});
    conv_requests.push_back('{whole: 32'd3600,     frac: 32'h0});
    conv_requests.push_back('{whole: 32'h0,        frac: 32'h80000000});
    conv_requests.push_back('{whole: 32'h0,        frac: 32'h1});
    conv_requests.push_back('{whole: 32'hAAAAAAAA, frac: 32'h55555555});
    conv_requests.push_back('{whole: 32'h55555555, frac: 32'hAAAAAAAA});
    conv_requests.push_back('{whole: 32'd12345,    frac: 32'h00010000});
    wait_drained();
    foreach (bases[p]) begin
      write_reg(fsrd_pkg::REG_DIGIT_BASE, bases[p]);
      write_reg(fsrd_pkg::REG_FRACTION_PLACES, places[p]);
      @(negedge clk);
      if (p == 0) begin
        // binary with all places: digit cap and the deepest fraction exponent
        conv_requests.push_back('{whole: 32'hFFFFFFFF, frac: 32'hFFFFFFFF});
        conv_requests.push_back('{whole: 32'h80000000, frac: 32'h0});
        conv_requests.push_back('{whole: 32'h0,        frac: 32'h1});
        conv_requests.push_back('{whole: 32'd1,        frac: 32'h80000000});
        conv_requests.push_back('{whole: 32'h0,        frac: 32'h0});
      end
      repeat (33) conv_requests.push_back(random_request());
      wait_drained();
    end
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** fixed_to_sparse_radix_digits: PASSED **");
    end else begin
      $display("** fixed_to_sparse_radix_digits: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/fsrd_pkg.sv
hdl/fixed_to_sparse_radix_digits.sv
tb/fixed_to_sparse_radix_digits_tb.sv
